>>> rtl/core/pcmgc_pkg.sv
// Package for the PCM-to-integer gain converter.
// Holds format codes, register indexes and the product-stage record; no dependencies.
`default_nettype none

package pcmgc_pkg;

  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S24 = 3'd2,
    FMT_S32 = 3'd3,
    FMT_F32 = 3'd4
  } fmt_t;

  typedef enum logic [1:0] {
    REG_INPUT_FORMAT = 2'd0,
    REG_OUTPUT_WIDTH = 2'd1,
    REG_VOLUME_GAIN  = 2'd2
  } reg_idx_t;

  localparam int GAIN_W = 17;
  localparam int PROD_W = 49;   // 32-bit magnitude times 17-bit gain
  localparam int SH_W   = 10;   // signed binary exponent of the product

  localparam logic [2:0]        RST_INPUT_FORMAT = 3'd1;
  localparam logic              RST_OUTPUT_WIDTH = 1'b0;
  localparam logic [GAIN_W-1:0] RST_VOLUME_GAIN  = 17'd65536;

  // Product stage: magnitude times gain, plus what the scaling stage needs.
  typedef struct packed {
    logic [PROD_W-1:0]      prod;
    logic signed [SH_W-1:0] shift;     // result = prod * 2^shift
    logic                   neg;
    logic                   half16;    // 16-bit output range
    logic                   zero;      // force 0 (NaN, inf times zero gain, unused code)
    logic                   sat;       // force extreme (infinity)
    logic                   bypass;    // u8 path: take bypass_value as is
    logic [31:0]            bypass_value;
    logic                   last;
  } prod_t;

endpackage

`default_nettype wire

>>> rtl/core/pcm_to_int_gain_converter.sv
// PCM sample format converter with volume gain, top level.
// Depends on pcmgc_pkg for format codes, register indexes and the stage record.
`default_nettype none

//  channel   signals                                          direction
//  --------  -----------------------------------------------  ---------
//  sample    sample_valid, sample_stall, sample_in, last_in    in
//  result    result_valid, result_stall, sample_out, last_out  out
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data         in
//
// One request per cycle, sustained while the result side does not stall. A request passes
// from its accepting edge to the output register through three registers: input,
// product (the one 32x17 multiplier) and result (shift and saturate).
// Reset (rst, synchronous) empties the pipe and loads the register defaults:
// s16 input, 32-bit output, unity gain. A stall on the result side holds the
// pipe only as far back as needed; empty stages keep filling meanwhile.

module pcm_to_int_gain_converter
  import pcmgc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // sample channel
  input  wire logic              sample_valid,
  output logic                   sample_stall,
  input  wire logic [31:0]       sample_in,
  input  wire logic              last_in,
  // result channel
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic signed [31:0]     sample_out,
  output logic                   last_out,
  // configuration channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [GAIN_W-1:0] cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Always ready; index 3 is ignored.
  // ---------------------------------------------------------------------------
  logic [2:0]        input_format;
  logic              output_width;
  logic [GAIN_W-1:0] volume_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_format <= RST_INPUT_FORMAT;
      output_width <= RST_OUTPUT_WIDTH;
      volume_gain  <= RST_VOLUME_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INPUT_FORMAT: input_format <= cfg_data[2:0];
        REG_OUTPUT_WIDTH: output_width <= cfg_data[0];
        REG_VOLUME_GAIN:  volume_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipe control: each stage advances when the stage after it is free.
  // ---------------------------------------------------------------------------
  logic  in_valid;
  logic  prod_valid;
  logic  out_free;
  logic  prod_free;
  logic  in_free;

  assign out_free     = !result_valid || !result_stall;
  assign prod_free    = !prod_valid || out_free;
  assign in_free      = !in_valid || prod_free;
  assign sample_stall = !in_free;

  // ---------------------------------------------------------------------------
  // Stage 1: input register.
  // ---------------------------------------------------------------------------
  logic [31:0] in_sample;
  logic        in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_free) begin
      in_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && in_free) begin
      in_sample <= sample_in;
      in_last   <= last_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: decode the sample into sign, magnitude and binary exponent, then
  // multiply the magnitude by the gain. Integer formats sit at exponent -16
  // (the gain's fraction); floats carry exponent e - 150 - 16 + (w - 1).
  // ---------------------------------------------------------------------------
  logic [31:0]       int_val;
  logic [31:0]       int_mag;
  logic [7:0]        f_exp;
  logic [22:0]       f_frac;
  logic [7:0]        f_exp_eff;
  logic [23:0]       f_mant;
  logic [31:0]       mul_a;
  logic              w16;
  prod_t             prod_next;
  prod_t             prod;

  assign w16    = output_width;
  assign f_exp  = in_sample[30:23];
  assign f_frac = in_sample[22:0];

  always_comb begin
    // Integer formats, aligned to a two's complement 32-bit value.
    case (input_format)
      FMT_S16: int_val = w16 ? {{16{in_sample[15]}}, in_sample[15:0]}
                             : {in_sample[15:0], 16'd0};
      FMT_S24: int_val = w16 ? {{16{in_sample[23]}}, in_sample[23:8]}
                             : {in_sample[23:0], 8'd0};
      FMT_S32: int_val = w16 ? {{16{in_sample[31]}}, in_sample[31:16]}
                             : in_sample;
      default: int_val = 32'd0;
    endcase
    // Magnitude of the most negative value wraps to 2^31, which is right.
    int_mag = int_val[31] ? (32'd0 - int_val) : int_val;

    // Subnormals: exponent one, no hidden bit.
    f_exp_eff = (f_exp == 8'd0) ? 8'd1 : f_exp;
    f_mant    = (f_exp == 8'd0) ? {1'b0, f_frac} : {1'b1, f_frac};

    prod_next              = '0;
    prod_next.half16       = w16;
    prod_next.last         = in_last;
    prod_next.shift        = -10'sd16;
    mul_a                  = int_mag;

    case (input_format)
      FMT_U8: begin
        prod_next.bypass       = 1'b1;
        prod_next.bypass_value = w16
            ? {{16{~in_sample[7]}}, ~in_sample[7], in_sample[6:0], 8'd0}
            : {~in_sample[7], in_sample[6:0], 24'd0};
      end
      FMT_S16, FMT_S24, FMT_S32: begin
        prod_next.neg = int_val[31];
      end
      FMT_F32: begin
        mul_a           = {8'd0, f_mant};
        prod_next.neg   = in_sample[31];
        prod_next.shift = $signed({2'b00, f_exp_eff}) - 10'sd167
                          + (w16 ? 10'sd16 : 10'sd32);
        if (f_exp == 8'hFF) begin
          // NaN, or infinity times zero gain, gives zero; else infinity saturates.
          if (f_frac != 23'd0 || volume_gain == '0) prod_next.zero = 1'b1;
          else                                      prod_next.sat  = 1'b1;
        end
      end
      default: begin
        prod_next.zero = 1'b1;
      end
    endcase

    prod_next.prod = {{(PROD_W-32){1'b0}}, mul_a} * {{(PROD_W-GAIN_W){1'b0}}, volume_gain};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_free) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && prod_free) begin
      prod <= prod_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: scale by 2^shift, truncate toward zero, saturate, apply sign; u8 takes its bypass value.
  // ---------------------------------------------------------------------------
  logic [31:0]            cap;
  logic [79:0]            left_val;
  logic [PROD_W-1:0]      right_val;
  logic [SH_W-1:0]        rshift;
  logic [31:0]            mag;
  logic signed [31:0]     result_next;

  always_comb begin
    // Negative range reaches one step further than positive.
    if (prod.half16) cap = prod.neg ? 32'h0000_8000 : 32'h0000_7FFF;
    else             cap = prod.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;

    left_val  = {{(80-PROD_W){1'b0}}, prod.prod} << prod.shift[4:0];
    rshift    = 10'd0 - prod.shift;
    right_val = prod.prod >> rshift[5:0];

    if (prod.zero || prod.prod == '0) begin
      mag = 32'd0;
    end else if (prod.sat) begin
      mag = cap;
    end else if (!prod.shift[SH_W-1]) begin
      // Left shift: anything at or past 2^32 is out of range already.
      if (prod.shift >= 10'sd32 || left_val > {48'd0, cap}) mag = cap;
      else                                                  mag = left_val[31:0];
    end else begin
      if (rshift >= 10'd63)                                       mag = 32'd0;
      else if (right_val > {{(PROD_W-32){1'b0}}, cap})            mag = cap;
      else                                                        mag = right_val[31:0];
    end

    if (prod.bypass) result_next = prod.bypass_value;
    else             result_next = prod.neg ? (32'sd0 - $signed(mag)) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && out_free) begin
      sample_out <= result_next;
      last_out   <= prod.last;
    end
  end

endmodule

`default_nettype wire
